>>> rtl/efr_pkg.sv
// efr_pkg: shared types and constants for the escaped frame receiver
// no dependencies
package efr_pkg;

  localparam logic [7:0] MARK_START   = 8'hfd;
  localparam logic [7:0] MARK_END     = 8'hfe;
  localparam logic [7:0] MARK_ESC     = 8'h7d;
  localparam logic [7:0] LEN_OVERHEAD = 8'd11;

  localparam int unsigned IDX_W = 9;
  localparam int unsigned LEN_W = 10;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         data;
    logic [IDX_W-1:0]   idx;
    logic [LEN_W-1:0]   len;
    logic               ok;
    logic               ovf;
    logic               last;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

>>> rtl/escaped_frame_receiver_core.sv
// escaped_frame_receiver_core: byte-stuffed frame receiver, top level
// depends on efr_pkg, efr_decode, efr_res_fifo
// result beats enter a four-entry queue as their byte is accepted
// throughput: one byte per cycle while the queue has room; an end marker
//   after a pending escape can give two beats, drained one per ready cycle
// reset: asynchronous active low; hunts for the start marker, queue empty
module escaped_frame_receiver_core #(
  parameter int unsigned MAX_FRAME = 512
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                rx_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      result_kind_o,
  output logic [7:0]                data_byte_o,
  output logic [efr_pkg::IDX_W-1:0] byte_index_o,
  output logic [efr_pkg::LEN_W-1:0] frame_len_o,
  output logic                      length_ok_o,
  output logic                      overflow_seen_o,
  output logic                      last_o
);
  import efr_pkg::*;

  logic  take;
  logic  room;
  push_t push;
  res_t  res;

  assign in_ready_o = room;
  assign take       = in_valid_i && room;

  efr_decode #(
    .MAX_FRAME(MAX_FRAME)
  ) u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take),
    .rx_byte_i(rx_byte_i),
    .push_o   (push)
  );

  efr_res_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .valid_o(out_valid_o),
    .ready_i(out_ready_i),
    .res_o  (res)
  );

  assign result_kind_o   = res.kind;
  assign data_byte_o     = res.data;
  assign byte_index_o    = res.idx;
  assign frame_len_o     = res.len;
  assign length_ok_o     = res.ok;
  assign overflow_seen_o = res.ovf;
  assign last_o          = res.last;

endmodule

>>> rtl/efr_decode.sv
// efr_decode: frame state and single-pass decode of one received byte
// depends on efr_pkg
module efr_decode #(
  parameter int unsigned MAX_FRAME = 512
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          take_i,
  input  logic [7:0]    rx_byte_i,
  output efr_pkg::push_t push_o
);
  import efr_pkg::*;

  localparam int unsigned CW = $clog2(MAX_FRAME + 1);
  localparam int unsigned SW = ((CW > 9) ? CW : 9) + 1;
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_FRAME);

  logic          in_frame_q, in_frame_d;
  logic          esc_q, esc_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [7:0]    decl_q, decl_d;
  logic          ovf_q, ovf_d;

  logic          do_take;
  logic [7:0]    take_val;
  logic          is_end;
  res_t          data_res;
  res_t          stat_res;
  logic [31:0]   cnt_wide;
  logic [31:0]   cnt_new_wide;
  logic          data_emit;

  always_comb begin
    in_frame_d = in_frame_q;
    esc_d      = esc_q;
    cnt_d      = cnt_q;
    decl_d     = decl_q;
    ovf_d      = ovf_q;
    do_take    = 1'b0;
    take_val   = rx_byte_i;
    is_end     = 1'b0;
    data_emit  = 1'b0;

    if (!in_frame_q) begin
      if (rx_byte_i == MARK_START) begin
        in_frame_d = 1'b1;
        esc_d      = 1'b0;
        cnt_d      = '0;
        decl_d     = '0;
        ovf_d      = 1'b0;
      end
    end else if (rx_byte_i == MARK_END) begin
      is_end     = 1'b1;
      do_take    = esc_q;
      take_val   = MARK_ESC + rx_byte_i;
      in_frame_d = 1'b0;
      esc_d      = 1'b0;
    end else if (esc_q) begin
      esc_d    = 1'b0;
      do_take  = 1'b1;
      take_val = MARK_ESC + rx_byte_i;
    end else if (rx_byte_i == MARK_ESC) begin
      esc_d = 1'b1;
    end else begin
      do_take = 1'b1;
    end

    if (do_take) begin
      if (cnt_q == MaxCnt) begin
        ovf_d = 1'b1;
      end else begin
        data_emit = 1'b1;
        if (cnt_q == '0) begin
          decl_d = take_val;
        end
        cnt_d = cnt_q + CW'(1);
      end
    end
  end

  assign cnt_wide     = 32'(cnt_q);
  assign cnt_new_wide = 32'(cnt_d);

  always_comb begin
    data_res      = '0;
    data_res.kind = KIND_DATA;
    data_res.data = take_val;
    data_res.idx  = cnt_wide[IDX_W-1:0];
    data_res.last = !is_end;

    stat_res      = '0;
    stat_res.kind = KIND_STATUS;
    stat_res.len  = cnt_new_wide[LEN_W-1:0];
    stat_res.ok   = ((SW'(decl_d) + SW'(LEN_OVERHEAD)) == SW'(cnt_d)) && !ovf_d;
    stat_res.ovf  = ovf_d;
    stat_res.last = 1'b1;

    push_o = '0;
    if (take_i) begin
      if (data_emit && is_end) begin
        push_o.n  = 2'd2;
        push_o.r0 = data_res;
        push_o.r1 = stat_res;
      end else if (data_emit) begin
        push_o.n  = 2'd1;
        push_o.r0 = data_res;
      end else if (is_end) begin
        push_o.n  = 2'd1;
        push_o.r0 = stat_res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      esc_q      <= 1'b0;
      cnt_q      <= '0;
      decl_q     <= '0;
      ovf_q      <= 1'b0;
    end else if (take_i) begin
      in_frame_q <= in_frame_d;
      esc_q      <= esc_d;
      cnt_q      <= cnt_d;
      decl_q     <= decl_d;
      ovf_q      <= ovf_d;
    end
  end

endmodule

>>> rtl/efr_res_fifo.sv
// efr_res_fifo: four-entry result queue, up to two writes and one read per cycle
// depends on efr_pkg
module efr_res_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  efr_pkg::push_t push_i,
  output logic           room_o,
  output logic           valid_o,
  input  logic           ready_i,
  output efr_pkg::res_t  res_o
);
  import efr_pkg::*;

  res_t       mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;
  logic       pop;
  logic [1:0] wr_next;

  assign valid_o = (cnt_q != 3'd0);
  assign room_o  = (cnt_q <= 3'd2);
  assign pop     = valid_o && ready_i;
  assign res_o   = mem_q[rd_q];
  assign wr_next = wr_q + 2'd1;

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_next] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + push_i.n;
      rd_q  <= rd_q + 2'(pop);
      cnt_q <= cnt_q + 3'(push_i.n) - 3'(pop);
    end
  end

endmodule

>>> tb/escaped_frame_receiver_core_tb.sv
// escaped_frame_receiver_core_tb: self-checking bench for the escaped frame receiver
// sends framed, escaped and malformed byte streams and checks every result beat
// depends on efr_pkg and escaped_frame_receiver_core
module escaped_frame_receiver_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import efr_pkg::*;

  localparam int FRAME_MAX  = 512;
  localparam int DRAIN_WAIT = 8;
  localparam int CYCLE_CAP  = 500000;

  typedef enum int {
    TAIL_END,
    TAIL_ESC_END,
    TAIL_CUT
  } frame_tail_e;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [7:0]        rx_byte_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic              result_kind_o;
  logic [7:0]        data_byte_o;
  logic [IDX_W-1:0]  byte_index_o;
  logic [LEN_W-1:0]  frame_len_o;
  logic              length_ok_o;
  logic              overflow_seen_o;
  logic              last_o;

  // deframer mirror state
  bit         rx_in_frame;
  bit         rx_esc;
  int         rx_count;
  logic [7:0] rx_first;
  bit         rx_ovf;

  res_t frame_results_q[$];
  res_t step_q[$];
  int   sent_cnt;
  int   err_cnt;
  int   cycle_cnt;
  bit   idle_on;

  escaped_frame_receiver_core #(
    .MAX_FRAME(FRAME_MAX)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_kind_o  (result_kind_o),
    .data_byte_o    (data_byte_o),
    .byte_index_o   (byte_index_o),
    .frame_len_o    (frame_len_o),
    .length_ok_o    (length_ok_o),
    .overflow_seen_o(overflow_seen_o),
    .last_o         (last_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic void store_decoded(input logic [7:0] v);
    res_t r;
    if (rx_count >= FRAME_MAX) begin
      rx_ovf = 1'b1;
    end else begin
      if (rx_count == 0) rx_first = v;
      r      = '0;
      r.kind = KIND_DATA;
      r.data = v;
      r.idx  = IDX_W'(rx_count);
      step_q.push_back(r);
      rx_count++;
    end
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    res_t st;
    step_q.delete();
    if (!rx_in_frame) begin
      if (b == MARK_START) begin
        rx_in_frame = 1'b1;
        rx_esc      = 1'b0;
        rx_count    = 0;
        rx_first    = '0;
        rx_ovf      = 1'b0;
      end
    end else if (b == MARK_END) begin
      if (rx_esc) store_decoded(MARK_ESC + b);
      st      = '0;
      st.kind = KIND_STATUS;
      st.len  = LEN_W'(rx_count);
      st.ok   = (int'(rx_first) + int'(LEN_OVERHEAD) == rx_count) && !rx_ovf;
      st.ovf  = rx_ovf;
      step_q.push_back(st);
      rx_in_frame = 1'b0;
      rx_esc      = 1'b0;
    end else if (rx_esc) begin
      rx_esc = 1'b0;
      store_decoded(MARK_ESC + b);
    end else if (b == MARK_ESC) begin
      rx_esc = 1'b1;
    end else begin
      store_decoded(b);
    end
    if (step_q.size() > 0) begin
      st      = step_q.pop_back();
      st.last = 1'b1;
      step_q.push_back(st);
    end
    foreach (step_q[i]) frame_results_q.push_back(step_q[i]);
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin : check_beat
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (frame_results_q.size() == 0) begin
        $error("result beat with nothing outstanding");
        err_cnt++;
      end else begin
        want = frame_results_q.pop_front();
        check_field("result_kind", 16'(want.kind), 16'(result_kind_o));
        check_field("data_byte", 16'(want.data), 16'(data_byte_o));
        check_field("byte_index", 16'(want.idx), 16'(byte_index_o));
        check_field("frame_len", 16'(want.len), 16'(frame_len_o));
        check_field("length_ok", 16'(want.ok), 16'(length_ok_o));
        check_field("overflow_seen", 16'(want.ovf), 16'(overflow_seen_o));
        check_field("last", 16'(want.last), 16'(last_o));
      end
    end
  end

  // downstream backpressure in bursts while idle_on is set
  initial begin
    out_ready_i = 1'b1;
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    deframe_byte(b);
    sent_cnt++;
    @(negedge clk_i);
  endtask

  task automatic send_value(input logic [7:0] v);
    if (v == MARK_END || v == MARK_ESC ||
        ($urandom_range(0, 7) == 0 && 8'(v - MARK_ESC) != MARK_END)) begin
      send_byte(MARK_ESC);
      send_byte(8'(v - MARK_ESC));
    end else begin
      send_byte(v);
    end
  endtask

  task automatic send_frame(input int len, input bit good, input frame_tail_e tail);
    logic [7:0] v;
    send_byte(MARK_START);
    for (int i = 0; i < len; i++) begin
      v = (good && i == 0) ? 8'(len - 11) : 8'($urandom_range(0, 255));
      send_value(v);
    end
    if (tail == TAIL_ESC_END) send_byte(MARK_ESC);
    if (tail != TAIL_CUT) send_byte(MARK_END);
  endtask

  task automatic test_hunting();
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(MARK_END);
    send_byte(MARK_ESC);
  endtask

  task automatic test_empty_frame();
    send_byte(MARK_START);
    send_byte(MARK_END);
  endtask

  // escaped markers, start marker as data, pending escape at the end, good length
  task automatic test_escapes_and_length();
    logic [7:0] seq [17] = '{MARK_START, MARK_ESC, 8'h83, MARK_START, MARK_ESC, MARK_ESC,
                             MARK_ESC, MARK_START, MARK_ESC, 8'h00, 8'hff, 8'h01, 8'h80,
                             8'h7f, 8'h55, MARK_ESC, MARK_END};
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic test_overflow();
    send_frame(FRAME_MAX - 1, 1'b0, TAIL_ESC_END);
    send_frame(FRAME_MAX + 1, 1'b0, TAIL_END);
  endtask

  task automatic test_random_frames(input int goal);
    int pick;
    while (sent_cnt < goal) begin
      pick = $urandom_range(0, 9);
      repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
      if (pick < 4)
        send_frame(($urandom_range(0, 15) == 0) ? 266 : $urandom_range(11, 40), 1'b1,
                   TAIL_END);
      else if (pick < 7)
        send_frame($urandom_range(0, 24), 1'b0, TAIL_END);
      else if (pick == 7)
        send_frame($urandom_range(0, 24), 1'($urandom_range(0, 1)), TAIL_ESC_END);
      else if (pick == 8)
        send_frame($urandom_range(1, 12), 1'b0, TAIL_CUT);
      else
        repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    test_random_frames(sent_cnt + 150);
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    rx_byte_i   = '0;
    idle_on     = 1'b1;
    sent_cnt    = 0;
    err_cnt     = 0;
    cycle_cnt   = 0;
    rx_in_frame = 1'b0;
    rx_esc      = 1'b0;
    rx_count    = 0;
    rx_first    = '0;
    rx_ovf      = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_hunting();
    test_empty_frame();
    test_escapes_and_length();
    test_overflow();
    test_random_frames(1600);
    test_steady_stream();
    in_valid_i <= 1'b0;

    while (frame_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (err_cnt == 0 && frame_results_q.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
